### src/assert_macros.svh
// Assertion helper macros for the pixel decoder checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/jlsd_pkg.sv
// ---------------------------------------------------------------------------
// jlsd_pkg: shared types and constants for the pixel decoder
// Context entry layout, register codes and the context reset value.
// ---------------------------------------------------------------------------
package jlsd_pkg;

    localparam int CONTEXTS    = 365;
    localparam int SAMPLE_BITS = 8;
    localparam int CTX_W       = 9;

    typedef enum logic [2:0] {
        REG_T1   = 3'd0,
        REG_T2   = 3'd1,
        REG_T3   = 3'd2,
        REG_RCNT = 3'd3,
        REG_CMAX = 3'd4,
        REG_CMIN = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]       asum;
        logic signed [7:0] bsum;
        logic signed [7:0] corr;
        logic [7:0]        cnt;
    } t_ctx_stat;

    localparam t_ctx_stat STAT_RESET = '{asum: 16'd4, bsum: 8'sd0,
                                         corr: 8'sd0, cnt: 8'd1};

    typedef struct packed {
        logic [7:0] t1;
        logic [7:0] t2;
        logic [7:0] t3;
        logic [7:0] rcnt;
        logic [6:0] cmax;
        logic [7:0] cmin;
    } t_cfg;

endpackage

### src/jlsd_ctx_calc.sv
// ---------------------------------------------------------------------------
// jlsd_ctx_calc: gradient quantization and context folding
// Produces the folded context index, sign flag and edge predictor.
// ---------------------------------------------------------------------------
module jlsd_ctx_calc (
    input  logic [7:0]           i_a,
    input  logic [7:0]           i_b,
    input  logic [7:0]           i_c,
    input  logic [7:0]           i_d,
    input  jlsd_pkg::t_cfg       i_cfg,
    output logic [8:0]           o_ctx,
    output logic                 o_neg,
    output logic [7:0]           o_med
);
    import jlsd_pkg::*;

    function automatic logic signed [3:0] quant(input logic signed [8:0] g,
                                                input t_cfg c);
        logic signed [9:0] t1, t2, t3, gg;
        begin
            t1 = signed'({2'b0, c.t1});
            t2 = signed'({2'b0, c.t2});
            t3 = signed'({2'b0, c.t3});
            gg = {g[8], g};
            if (gg <= -t3) quant = -4'sd4;
            else if (gg <= -t2) quant = -4'sd3;
            else if (gg <= -t1) quant = -4'sd2;
            else if (gg < 0) quant = -4'sd1;
            else if (gg == 0) quant = 4'sd0;
            else if (gg < t1) quant = 4'sd1;
            else if (gg < t2) quant = 4'sd2;
            else if (gg < t3) quant = 4'sd3;
            else quant = 4'sd4;
        end
    endfunction

    logic signed [3:0] q0, q1, q2, f0, f1, f2;
    logic signed [10:0] ctx_s;
    logic [7:0] mn, mx;
    logic [9:0] sum;

    always_comb begin
        q0 = quant(signed'({1'b0, i_d}) - signed'({1'b0, i_b}), i_cfg);
        q1 = quant(signed'({1'b0, i_b}) - signed'({1'b0, i_c}), i_cfg);
        q2 = quant(signed'({1'b0, i_c}) - signed'({1'b0, i_a}), i_cfg);
        o_neg = (q0 < 0) || (q0 == 0 && (q1 < 0 || (q1 == 0 && q2 < 0)));
        f0 = o_neg ? -q0 : q0;
        f1 = o_neg ? -q1 : q1;
        f2 = o_neg ? -q2 : q2;
        ctx_s = 11'(f0) * 11'sd81 + 11'(f1) * 11'sd9 + 11'(f2);
        o_ctx = ctx_s[8:0];
        mn = (i_a < i_b) ? i_a : i_b;
        mx = (i_a > i_b) ? i_a : i_b;
        sum = {2'b0, i_a} + {2'b0, i_b} - {2'b0, i_c};
        if (i_c >= mx) o_med = mn;
        else if (i_c <= mn) o_med = mx;
        else o_med = sum[7:0];
    end
endmodule

### src/jlsd_update.sv
// ---------------------------------------------------------------------------
// jlsd_update: prediction correction, k, unmapping and statistics update
// ---------------------------------------------------------------------------
module jlsd_update (
    input  jlsd_pkg::t_ctx_stat  i_stat,
    input  logic [7:0]           i_med,
    input  logic                 i_neg,
    input  logic [8:0]           i_merr,
    input  jlsd_pkg::t_cfg       i_cfg,
    output jlsd_pkg::t_ctx_stat  o_stat,
    output logic [7:0]           o_sample,
    output logic [3:0]           o_k
);
    import jlsd_pkg::*;

    logic signed [10:0] pred;
    logic [7:0]         predc;
    logic [3:0]         k;
    logic               found;
    logic [23:0]        nk;
    logic signed [10:0] err, bs, nn, lim;
    logic [10:0]        aerr;
    logic [16:0]        as;
    logic signed [8:0]  cor;

    always_comb begin
        pred = 11'(signed'({1'b0, i_med})) +
               (i_neg ? -11'(i_stat.corr) : 11'(i_stat.corr));
        if (pred > 11'sd255) predc = 8'd255;
        else if (pred < 0) predc = 8'd0;
        else predc = pred[7:0];

        k = 4'd15;
        found = 1'b0;
        for (int j = 0; j < 15; j++) begin
            nk = {16'b0, i_stat.cnt} << j;
            if (!found && nk >= {8'b0, i_stat.asum}) begin
                k = 4'(j);
                found = 1'b1;
            end
        end

        bs = 11'(i_stat.bsum);
        nn = signed'({3'b0, i_stat.cnt});
        if (k == 0 && 2 * bs <= -nn) begin
            if (i_merr[0]) err = signed'({3'b0, i_merr[8:1]});
            else err = -signed'({3'b0, i_merr[8:1]}) - 11'sd1;
        end else begin
            if (i_merr[0]) err = -signed'({2'b0, i_merr[8:1]} + 10'd1);
            else err = signed'({3'b0, i_merr[8:1]});
        end

        if (i_cfg.rcnt < 8'd2) lim = 11'sd2;
        else if (i_cfg.rcnt > 8'd128) lim = 11'sd128;
        else lim = signed'({3'b0, i_cfg.rcnt});

        bs = bs + err;
        aerr = err[10] ? 11'(-err) : 11'(err);
        as = {1'b0, i_stat.asum} + {6'b0, aerr};
        if (as > 17'd65535) as = 17'd65535;
        if (nn >= lim) begin
            as = as >> 1;
            bs = bs >>> 1;
            nn = nn >>> 1;
        end
        nn = nn + 11'sd1;

        cor = 9'(i_stat.corr);
        if (bs <= -nn) begin
            bs = bs + nn;
            if (i_stat.corr > signed'(i_cfg.cmin)) cor = cor - 9'sd1;
            if (bs <= -nn) bs = -nn + 11'sd1;
        end else if (bs > 0) begin
            bs = bs - nn;
            if (cor < signed'({2'b0, i_cfg.cmax})) cor = cor + 9'sd1;
            if (bs > 0) bs = 11'sd0;
        end

        o_stat.asum = as[15:0];
        o_stat.bsum = bs[7:0];
        o_stat.corr = cor[7:0];
        o_stat.cnt  = nn[7:0];
        if (i_neg) err = -err;
        o_sample = 8'(err + 11'(signed'({3'b0, predc})));
        o_k = k;
    end
endmodule

### src/jpegls_regular_pixel_decoder_core.sv
// ---------------------------------------------------------------------------
// jpegls_regular_pixel_decoder_core: regular-mode sample reconstruction
// One sample per cycle unless stalled, context stats in a synchronous store.
// ---------------------------------------------------------------------------
// Takes one sample per clock while o_stall is low. The gradients of an
// arriving transfer are quantized and folded straight off the input
// ports, so the context store is read with a registered read at the
// accepting edge, together with the input stage. The stage corrects the
// prediction, derives k, unmaps the error, and as the item leaves it
// writes the updated statistics back and loads the output register. When
// the item leaving the stage and the item arriving use the same context,
// the fresh statistics are forwarded into the stage, so back to back
// samples in one context need no bubble. After reset release a clearing
// pass writes A=4, B=0, C=0, N=1 into all 365 entries, one per cycle; the
// input stalls for the whole pass. After that the input stalls only while
// the result register is full and its transfer is stalled.
module jpegls_regular_pixel_decoder_core #(
    parameter int CONTEXTS = jlsd_pkg::CONTEXTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_left_pixel,
    input  logic [7:0]  i_above_pixel,
    input  logic [7:0]  i_above_left_pixel,
    input  logic [7:0]  i_above_right_pixel,
    input  logic [8:0]  i_mapped_error,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_sample,
    output logic [8:0]  o_context_index,
    output logic [3:0]  o_golomb_k,
    output logic        o_sign_flipped
);
    import jlsd_pkg::*;

    t_cfg r_cfg;

    // clearing pass over the store after reset
    logic             r_clr;
    logic [CTX_W-1:0] r_clr_idx;

    // input stage
    logic             r_in_vld;
    logic [CTX_W-1:0] r_ctx;
    logic             r_neg;
    logic [7:0]       r_med;
    logic [8:0]       r_merr;

    // context store, its registered read and the forwarding path
    t_ctx_stat r_mem [CONTEXTS];
    t_ctx_stat r_rd_mem;
    t_ctx_stat r_fwd_stat;
    logic      r_fwd;

    logic [CTX_W-1:0] ctx;
    logic             neg;
    logic [7:0]       med, smp;
    logic [3:0]       k;
    t_ctx_stat        rd, wr;
    logic             advance, accept, retire;

    // the input stage moves when the result register can take its item
    assign advance = !o_valid || !i_stall;
    assign o_stall = r_clr || (r_in_vld && !advance);
    assign accept  = i_valid && !o_stall;
    assign retire  = r_in_vld && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{t1: 8'd3, t2: 8'd7, t3: 8'd21, rcnt: 8'd64,
                       cmax: 7'd127, cmin: 8'h80};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_T1:   r_cfg.t1   <= i_cfg_data;
                REG_T2:   r_cfg.t2   <= i_cfg_data;
                REG_T3:   r_cfg.t3   <= i_cfg_data;
                REG_RCNT: r_cfg.rcnt <= i_cfg_data;
                REG_CMAX: r_cfg.cmax <= i_cfg_data[6:0];
                REG_CMIN: r_cfg.cmin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_clr) begin
            if (r_clr_idx == CTX_W'(CONTEXTS - 1)) r_clr <= 1'b0;
            r_clr_idx <= r_clr_idx + CTX_W'(1);
        end
    end

    jlsd_ctx_calc u_ctx (
        .i_a   (i_left_pixel),
        .i_b   (i_above_pixel),
        .i_c   (i_above_left_pixel),
        .i_d   (i_above_right_pixel),
        .i_cfg (r_cfg),
        .o_ctx (ctx),
        .o_neg (neg),
        .o_med (med)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctx  <= ctx;
            r_neg  <= neg;
            r_med  <= med;
            r_merr <= i_mapped_error;
        end
    end

    // read at the accepting edge; a write to the same entry at that edge
    // is not visible yet, so take the update directly
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_mem   <= r_mem[ctx];
            r_fwd      <= retire && (r_ctx == ctx);
            r_fwd_stat <= wr;
        end
    end

    assign rd = r_fwd ? r_fwd_stat : r_rd_mem;

    jlsd_update u_upd (
        .i_stat   (rd),
        .i_med    (r_med),
        .i_neg    (r_neg),
        .i_merr   (r_merr),
        .i_cfg    (r_cfg),
        .o_stat   (wr),
        .o_sample (smp),
        .o_k      (k)
    );

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_idx] <= STAT_RESET;
        end else if (retire) begin
            r_mem[r_ctx] <= wr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (advance) begin
            o_valid <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            o_sample        <= smp;
            o_context_index <= r_ctx;
            o_golomb_k      <= k;
            o_sign_flipped  <= r_neg;
        end
    end
endmodule

### src/jlsd_checker.sv
// ---------------------------------------------------------------------------
// jlsd_checker: port-level checks for the pixel decoder
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jlsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [8:0] o_context_index,
    input logic       o_sign_flipped,
    input logic [7:0] o_sample
);
    `CHK_IMPLY(a_ctx_range, i_clk, i_rst_n, o_valid, o_context_index < 9'd365,
        "context index out of range")
    `CHK_IMPLY(a_flat_ctx, i_clk, i_rst_n, o_valid && o_context_index == 9'd0,
        !o_sign_flipped, "flat context flagged as flipped")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_sample), "stalled result changed")
    `CHK_IMPLY(a_no_stall_empty, i_clk, i_rst_n, o_valid && !i_stall, !o_stall,
        "input stalled while output drains")
endmodule

bind jpegls_regular_pixel_decoder_core jlsd_checker u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_context_index (o_context_index),
    .o_sign_flipped  (o_sign_flipped),
    .o_sample        (o_sample)
);
